@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rss_pkg.sv @@
// Package with the queue status type shared by the statistics modules.
`timescale 1ns / 1ps
package rss_pkg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/rss_queue.sv @@
// Two-entry queue that carries accumulator snapshots from the front to the back.
`timescale 1ns / 1ps
module rss_queue #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output rss_pkg::t_q_stat   o_stat
);
    import rss_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule

@@ rtl/core/rss_front.sv @@
// Front: updates count, sum, sum of squares, min and max per sample until saturated.
`timescale 1ns / 1ps
module rss_front #(
    parameter int SB = 16,
    parameter int CB = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SB-1:0]          i_sample,
    input  rss_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output logic [3*CB+5*SB-2:0]          o_snap
);
    import rss_pkg::*;

    localparam int SUMW = SB + CB;
    localparam int SQW  = 2 * SB - 2 + CB;

    logic [CB-1:0]          r_count;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sq;
    logic signed [SB-1:0]   r_min;
    logic signed [SB-1:0]   r_max;

    logic [CB-1:0]          n_count;
    logic signed [SUMW-1:0] n_sum;
    logic [SQW-1:0]         n_sq;
    logic signed [SB-1:0]   n_min;
    logic signed [SB-1:0]   n_max;
    logic                   w_sat;
    logic signed [2*SB-1:0] w_square;

    assign o_ready  = !i_q_stat.full;
    assign o_push   = i_valid && o_ready;
    assign w_sat    = &r_count;
    assign w_square = i_sample * i_sample;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_min   = r_min;
        n_max   = r_max;
        if (!w_sat) begin
            n_count = r_count + CB'(1);
            n_sum   = r_sum + SUMW'(i_sample);
            n_sq    = r_sq + SQW'($unsigned(w_square));
            if (r_count == '0) begin
                n_min = i_sample;
                n_max = i_sample;
            end else begin
                if (i_sample < r_min) n_min = i_sample;
                if (i_sample > r_max) n_max = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (o_push) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_snap = {w_sat, n_count, n_min, n_max, n_sum, n_sq};
endmodule

@@ rtl/core/rss_back.sv @@
// Back part: sequencer with a serial multiplier, divider and square root for the derived values.
`timescale 1ns / 1ps
module rss_back #(
    parameter int SB = 16,
    parameter int CB = 24,
    parameter int F  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rss_pkg::t_q_stat                i_q_stat,
    input  logic [3*CB+5*SB-2:0]            i_snap,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [CB-1:0]                   o_count,
    output logic signed [SB-1:0]            o_minimum,
    output logic signed [SB-1:0]            o_maximum,
    output logic signed [SB+CB-1:0]         o_total,
    output logic [2*SB-2+CB-1:0]            o_total_squares,
    output logic signed [SB+F-1:0]          o_average,
    output logic [2*SB-1+F-1:0]             o_variance_population,
    output logic [2*SB+F-1:0]               o_variance_sample,
    output logic [SB+F-1:0]                 o_deviation_population,
    output logic [SB+F:0]                   o_deviation_sample,
    output logic                            o_saturated
);
    import rss_pkg::*;

    localparam int SUMW = SB + CB;
    localparam int SQW  = 2 * SB - 2 + CB;
    localparam int MULW = SQW + CB;
    localparam int DIVW = MULW + 2 * F;
    localparam int DENW = 2 * CB;
    localparam int K    = SB + F + 1;
    localparam int AVGW = SB + F;
    localparam int VPW  = 2 * SB - 1 + F;
    localparam int VSW  = 2 * SB + F;
    localparam int STW  = $clog2(DIVW + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MNQ  = 4'd1;
    localparam logic [3:0] ST_MSS  = 4'd2;
    localparam logic [3:0] ST_MNN  = 4'd3;
    localparam logic [3:0] ST_DAVG = 4'd4;
    localparam logic [3:0] ST_DVP  = 4'd5;
    localparam logic [3:0] ST_SQP  = 4'd6;
    localparam logic [3:0] ST_DVS  = 4'd7;
    localparam logic [3:0] ST_SQS  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]             r_state;
    logic [STW-1:0]         r_step;
    logic                   r_ovalid;

    logic                   r_sat;
    logic [CB-1:0]          r_n;
    logic signed [SB-1:0]   r_min;
    logic signed [SB-1:0]   r_max;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sq;
    logic [SUMW-1:0]        r_mag;

    logic [MULW-1:0]        r_ma;
    logic [SUMW-1:0]        r_mb;
    logic [MULW-1:0]        r_acc;
    logic [MULW-1:0]        r_nq;
    logic [MULW-1:0]        r_num;
    logic [DENW-1:0]        r_nn;

    logic [DIVW-1:0]        r_dd;
    logic [DENW-1:0]        r_den;
    logic [DENW-1:0]        r_rem;
    logic [DIVW-1:0]        r_q;
    logic [DIVW-1:0]        r_avg;
    logic [DIVW-1:0]        r_qp;
    logic [DIVW-1:0]        r_qs;

    logic [2*K-1:0]         r_sx;
    logic [K-1:0]           r_root;
    logic [K+1:0]           r_srem;
    logic [K-1:0]           r_dp;
    logic [K-1:0]           r_ds;

    logic [CB-1:0]          o_count_r;
    logic signed [SB-1:0]   o_min_r;
    logic signed [SB-1:0]   o_max_r;
    logic signed [SUMW-1:0] o_sum_r;
    logic [SQW-1:0]         o_sq_r;
    logic [AVGW-1:0]        o_avg_r;
    logic [VPW-1:0]         o_vp_r;
    logic [VSW-1:0]         o_vs_r;
    logic [AVGW-1:0]        o_dp_r;
    logic [K-1:0]           o_ds_r;
    logic                   o_sat_r;

    logic                   w_sat;
    logic [CB-1:0]          w_n;
    logic signed [SB-1:0]   w_min;
    logic signed [SB-1:0]   w_max;
    logic signed [SUMW-1:0] w_sum;
    logic [SQW-1:0]         w_sq;
    logic [MULW-1:0]        w_acc;
    logic [DENW:0]          w_rsh;
    logic                   w_ge;
    logic [DENW-1:0]        w_rem;
    logic [DIVW-1:0]        w_q;
    logic [K+1:0]           w_t;
    logic [K+1:0]           w_trial;
    logic                   w_sge;
    logic [K+1:0]           w_srem;
    logic [K-1:0]           w_root;
    logic                   w_last;
    logic [AVGW-1:0]        w_avg;

    assign {w_sat, w_n, w_min, w_max, w_sum, w_sq} = i_snap;
    assign o_pop  = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign w_last = (r_step == '0);

    assign w_acc   = r_mb[0] ? r_acc + r_ma : r_acc;
    assign w_rsh   = {r_rem, r_dd[DIVW-1]};
    assign w_ge    = w_rsh >= {1'b0, r_den};
    assign w_rem   = w_ge ? DENW'(w_rsh - {1'b0, r_den}) : w_rsh[DENW-1:0];
    assign w_q     = {r_q[DIVW-2:0], w_ge};
    assign w_t     = {r_srem[K-1:0], r_sx[2*K-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_sge   = w_t >= w_trial;
    assign w_srem  = w_sge ? w_t - w_trial : w_t;
    assign w_root  = {r_root[K-2:0], w_sge};
    assign w_avg   = r_sum[SUMW-1] ? AVGW'(-r_avg[AVGW-1:0]) : r_avg[AVGW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_sat   <= w_sat;
                        r_n     <= w_n;
                        r_min   <= w_min;
                        r_max   <= w_max;
                        r_sum   <= w_sum;
                        r_sq    <= w_sq;
                        r_mag   <= w_sum[SUMW-1] ? SUMW'(-w_sum) : w_sum;
                        r_ma    <= MULW'(w_sq);
                        r_mb    <= SUMW'(w_n);
                        r_acc   <= '0;
                        r_step  <= STW'(SUMW - 1);
                        r_state <= ST_MNQ;
                    end
                end
                ST_MNQ, ST_MSS, ST_MNN: begin
                    if (w_last) begin
                        r_acc <= '0;
                        if (r_state == ST_MNQ) begin
                            r_nq    <= w_acc;
                            r_ma    <= MULW'(r_mag);
                            r_mb    <= r_mag;
                            r_step  <= STW'(SUMW - 1);
                            r_state <= ST_MSS;
                        end else if (r_state == ST_MSS) begin
                            r_num   <= r_nq - w_acc;
                            r_ma    <= MULW'(r_n);
                            r_mb    <= SUMW'(r_n);
                            r_step  <= STW'(SUMW - 1);
                            r_state <= ST_MNN;
                        end else begin
                            r_nn    <= w_acc[DENW-1:0];
                            r_dd    <= DIVW'(r_mag) << F;
                            r_den   <= DENW'(r_n);
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_step  <= STW'(DIVW - 1);
                            r_state <= ST_DAVG;
                        end
                    end else begin
                        r_acc  <= w_acc;
                        r_ma   <= {r_ma[MULW-2:0], 1'b0};
                        r_mb   <= r_mb >> 1;
                        r_step <= r_step - STW'(1);
                    end
                end
                ST_DAVG, ST_DVP, ST_DVS: begin
                    if (w_last) begin
                        if (r_state == ST_DAVG) begin
                            r_avg   <= w_q;
                            r_dd    <= DIVW'(r_num) << (2 * F);
                            r_den   <= r_nn;
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_step  <= STW'(DIVW - 1);
                            r_state <= ST_DVP;
                        end else begin
                            if (r_state == ST_DVP) begin
                                r_qp    <= w_q;
                                r_state <= ST_SQP;
                            end else begin
                                r_qs    <= w_q;
                                r_state <= ST_SQS;
                            end
                            r_sx   <= w_q[2*K-1:0];
                            r_root <= '0;
                            r_srem <= '0;
                            r_step <= STW'(K - 1);
                        end
                    end else begin
                        r_dd   <= {r_dd[DIVW-2:0], 1'b0};
                        r_rem  <= w_rem;
                        r_q    <= w_q;
                        r_step <= r_step - STW'(1);
                    end
                end
                ST_SQP, ST_SQS: begin
                    if (w_last) begin
                        if (r_state == ST_SQS) begin
                            r_ds    <= w_root;
                            r_state <= ST_DONE;
                        end else begin
                            r_dp <= w_root;
                            if (r_n > CB'(1)) begin
                                r_dd    <= DIVW'(r_num) << (2 * F);
                                r_den   <= r_nn - DENW'(r_n);
                                r_rem   <= '0;
                                r_q     <= '0;
                                r_step  <= STW'(DIVW - 1);
                                r_state <= ST_DVS;
                            end else begin
                                r_qs    <= '0;
                                r_ds    <= '0;
                                r_state <= ST_DONE;
                            end
                        end
                    end else begin
                        r_sx   <= {r_sx[2*K-3:0], 2'b00};
                        r_root <= w_root;
                        r_srem <= w_srem;
                        r_step <= r_step - STW'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid  <= 1'b1;
                        o_count_r <= r_n;
                        o_min_r   <= r_min;
                        o_max_r   <= r_max;
                        o_sum_r   <= r_sum;
                        o_sq_r    <= r_sq;
                        o_avg_r   <= w_avg;
                        o_vp_r    <= r_qp[F +: VPW];
                        o_vs_r    <= r_qs[F +: VSW];
                        o_dp_r    <= r_dp[AVGW-1:0];
                        o_ds_r    <= r_ds;
                        o_sat_r   <= r_sat;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid                = r_ovalid;
    assign o_count                = o_count_r;
    assign o_minimum              = o_min_r;
    assign o_maximum              = o_max_r;
    assign o_total                = o_sum_r;
    assign o_total_squares        = o_sq_r;
    assign o_average              = o_avg_r;
    assign o_variance_population  = o_vp_r;
    assign o_variance_sample      = o_vs_r;
    assign o_deviation_population = o_dp_r;
    assign o_deviation_sample     = o_ds_r;
    assign o_saturated            = o_sat_r;
endmodule

@@ rtl/core/running_sample_statistics_top.sv @@
// Top level of the running sample statistics block.
//
//   Channel   Direction  Handshake           Payload
//   sample    in         i_valid / o_ready   i_sample
//   result    out        o_valid / i_ready   o_count .. o_saturated
//
// The front updates the accumulators in the cycle an item is accepted.
// The back computes the derived values of each item with its one serial
// multiplier, divider and square root, and takes no new item until done.
// A sample whose count is one skips the second division and square root.
// A two-entry queue lets the front take items while the back is busy.
// Reset is synchronous and active low and clears the accumulators.
`timescale 1ns / 1ps
module running_sample_statistics_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic signed [SAMPLE_BITS-1:0]               i_sample,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output logic [COUNT_BITS-1:0]                       o_count,
    output logic signed [SAMPLE_BITS-1:0]               o_minimum,
    output logic signed [SAMPLE_BITS-1:0]               o_maximum,
    output logic signed [SAMPLE_BITS+COUNT_BITS-1:0]    o_total,
    output logic [2*SAMPLE_BITS-2+COUNT_BITS-1:0]       o_total_squares,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]     o_average,
    output logic [2*SAMPLE_BITS-1+FRAC_BITS-1:0]        o_variance_population,
    output logic [2*SAMPLE_BITS+FRAC_BITS-1:0]          o_variance_sample,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0]            o_deviation_population,
    output logic [SAMPLE_BITS+FRAC_BITS:0]              o_deviation_sample,
    output logic                                        o_saturated
);
    import rss_pkg::*;

    localparam int SNAPW = 3 * COUNT_BITS + 5 * SAMPLE_BITS - 1;

    t_q_stat          w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [SNAPW-1:0] w_snap_in;
    logic [SNAPW-1:0] w_snap_out;

    rss_front #(
        .SB (SAMPLE_BITS),
        .CB (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_snap   (w_snap_in)
    );

    rss_queue #(
        .WIDTH (SNAPW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .i_pop   (w_pop),
        .o_data  (w_snap_out),
        .o_stat  (w_q_stat)
    );

    rss_back #(
        .SB (SAMPLE_BITS),
        .CB (COUNT_BITS),
        .F  (FRAC_BITS)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_q_stat               (w_q_stat),
        .i_snap                 (w_snap_out),
        .o_pop                  (w_pop),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_count                (o_count),
        .o_minimum              (o_minimum),
        .o_maximum              (o_maximum),
        .o_total                (o_total),
        .o_total_squares        (o_total_squares),
        .o_average              (o_average),
        .o_variance_population  (o_variance_population),
        .o_variance_sample      (o_variance_sample),
        .o_deviation_population (o_deviation_population),
        .o_deviation_sample     (o_deviation_sample),
        .o_saturated            (o_saturated)
    );
endmodule

@@ rtl/core/rss_checker.sv @@
// Checker on the top level's ports, attached to the top level by a bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rss_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    parameter int FRAC_BITS   = 8
) (
    input logic                                        i_clk,
    input logic                                        i_rst_n,
    input logic                                        i_valid,
    input logic                                        o_ready,
    input logic signed [SAMPLE_BITS-1:0]               i_sample,
    input logic                                        o_valid,
    input logic                                        i_ready,
    input logic [COUNT_BITS-1:0]                       o_count,
    input logic signed [SAMPLE_BITS-1:0]               o_minimum,
    input logic signed [SAMPLE_BITS-1:0]               o_maximum,
    input logic signed [SAMPLE_BITS+COUNT_BITS-1:0]    o_total,
    input logic [2*SAMPLE_BITS-2+COUNT_BITS-1:0]       o_total_squares,
    input logic signed [SAMPLE_BITS+FRAC_BITS-1:0]     o_average,
    input logic [2*SAMPLE_BITS-1+FRAC_BITS-1:0]        o_variance_population,
    input logic [2*SAMPLE_BITS+FRAC_BITS-1:0]          o_variance_sample,
    input logic [SAMPLE_BITS+FRAC_BITS-1:0]            o_deviation_population,
    input logic [SAMPLE_BITS+FRAC_BITS:0]              o_deviation_sample,
    input logic                                        o_saturated
);
    `RSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_total), "Result item changed while stalled.")
    `RSS_ASSERT_NOW(a_sat_full, i_clk, i_rst_n, o_valid && o_saturated, &o_count, "Saturated flag with count not full.")
    `RSS_ASSERT_NOW(a_min_max, i_clk, i_rst_n, o_valid, o_minimum <= o_maximum, "Minimum above maximum.")
    `RSS_ASSERT_NOW(a_one_sample, i_clk, i_rst_n, o_valid && o_count == 1, o_variance_sample == 0 && o_deviation_sample == 0 && o_variance_population == 0, "Nonzero variance for a single sample.")
endmodule

bind running_sample_statistics_top rss_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
) u_rss_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the running sample statistics block.
`timescale 1ns / 1ps
module tb_top;

    localparam int SW = 16;
    localparam int CW = 24;
    localparam int FW = 8;
    localparam int NUM_ITEMS = 1050;
    localparam int DRAIN_AT = 500;
    localparam int LONG_HOLD = 3000;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [CW-1:0]         count;
        logic [SW-1:0]         minimum;
        logic [SW-1:0]         maximum;
        logic [SW+CW-1:0]      total;
        logic [2*SW-2+CW-1:0]  total_squares;
        logic [SW+FW-1:0]      average;
        logic [2*SW-1+FW-1:0]  variance_population;
        logic [2*SW+FW-1:0]    variance_sample;
        logic [SW+FW-1:0]      deviation_population;
        logic [SW+FW:0]        deviation_sample;
        logic                  saturated;
    } t_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [SW-1:0] i_sample = '0;
    logic o_ready, o_valid;
    t_stats got;

    logic signed [SW-1:0] pending_samples[$];
    t_stats expected_stats[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit drained = 1'b0;
    bit held = 1'b0;
    longint cycles = 0;

    longint unsigned acc_count = 0;
    logic signed [63:0] acc_sum = '0;
    logic [127:0] acc_squares = '0;
    logic signed [SW-1:0] acc_min = '0;
    logic signed [SW-1:0] acc_max = '0;

    running_sample_statistics_top #(
        .SAMPLE_BITS(SW),
        .COUNT_BITS(CW),
        .FRAC_BITS(FW)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sample(i_sample),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_count(got.count),
        .o_minimum(got.minimum),
        .o_maximum(got.maximum),
        .o_total(got.total),
        .o_total_squares(got.total_squares),
        .o_average(got.average),
        .o_variance_population(got.variance_population),
        .o_variance_sample(got.variance_sample),
        .o_deviation_population(got.deviation_population),
        .o_deviation_sample(got.deviation_sample),
        .o_saturated(got.saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_sqrt(logic [127:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic accumulate_sample(logic signed [SW-1:0] x);
        t_stats e;
        logic [127:0] mag, diff, nn, nm, mean_q;
        longint signed xs;
        xs = x;
        e.saturated = (acc_count >= (64'd1 << CW) - 1);
        if (!e.saturated) begin
            if (acc_count == 0) begin
                acc_min = x;
                acc_max = x;
            end else begin
                if (x < acc_min) acc_min = x;
                if (x > acc_max) acc_max = x;
            end
            acc_sum = acc_sum + xs;
            acc_squares = acc_squares + 128'(xs * xs);
            acc_count++;
        end
        mag = (acc_sum < 0) ? 128'(-acc_sum) : 128'(acc_sum);
        mean_q = (mag << FW) / acc_count;
        diff = acc_squares * acc_count - mag * mag;
        nn = acc_count * acc_count;
        nm = acc_count * (acc_count - 1);
        e.count = acc_count;
        e.minimum = acc_min;
        e.maximum = acc_max;
        e.total = acc_sum;
        e.total_squares = acc_squares;
        e.average = (acc_sum < 0) ? -mean_q : mean_q;
        e.variance_population = (diff << FW) / nn;
        e.deviation_population = floor_sqrt((diff << (2 * FW)) / nn);
        if (acc_count >= 2) begin
            e.variance_sample = (diff << FW) / nm;
            e.deviation_sample = floor_sqrt((diff << (2 * FW)) / nm);
        end else begin
            e.variance_sample = '0;
            e.deviation_sample = '0;
        end
        expected_stats.push_back(e);
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accumulate_sample(i_sample);
                sent++;
            end
            if (i_valid && !o_ready) begin
                i_valid <= 1'b1;
            end else if (sent == DRAIN_AT && !drained) begin
                i_valid <= 1'b0;
                if (expected_stats.size() == 0 && !(i_valid && o_ready)) begin
                    drained <= 1'b1;
                end
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_samples.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_sample <= pending_samples.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (received == 100 && !held) begin
            held <= 1'b1;
            i_ready <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(1, 800);
            end
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid && i_ready) begin
            received++;
            if (expected_stats.size() == 0) begin
                errors++;
                $display("%0t unexpected result, count %0d", $time, got.count);
            end else begin
                e = expected_stats.pop_front();
                compare_field("count", e.count, got.count);
                compare_field("minimum", e.minimum, got.minimum);
                compare_field("maximum", e.maximum, got.maximum);
                compare_field("total", e.total, got.total);
                compare_field("total_squares", e.total_squares, got.total_squares);
                compare_field("average", e.average, got.average);
                compare_field("variance_population", e.variance_population,
                              got.variance_population);
                compare_field("variance_sample", e.variance_sample, got.variance_sample);
                compare_field("deviation_population", e.deviation_population,
                              got.deviation_population);
                compare_field("deviation_sample", e.deviation_sample, got.deviation_sample);
                compare_field("saturated", e.saturated, got.saturated);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic signed [SW-1:0] v;
        pending_samples = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1, 16'sd1, 16'sh5555,
                            -16'sh5556, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000,
                            16'sd0, 16'sd256, -16'sd256, 16'sh00ff};
        for (int k = pending_samples.size(); k < NUM_ITEMS; k++) begin
            case ($urandom_range(0, 5))
                0: v = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
                1: v = $signed(16'($urandom_range(0, 15))) - 16'sd8;
                default: v = $urandom;
            endcase
            pending_samples.push_back(v);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pending_samples.size() != 0 || i_valid || expected_stats.size() != 0);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rss_pkg.sv
rtl/core/rss_queue.sv
rtl/core/rss_front.sv
rtl/core/rss_back.sv
rtl/core/running_sample_statistics_top.sv
rtl/core/rss_checker.sv
verif/tb_top.sv
